// File: design/gtd_pkg.sv
package gtd_pkg;

  // digit width of the shared multiplier (DIG_W x DIG_W unsigned)
  localparam int DIG_W       = 24;
  // operand bus wide enough for three digits
  localparam int OPW         = 3 * DIG_W;
  localparam int IDX_W       = 2;
  // width of the product shift amount into the accumulator
  localparam int SH_W        = 7;
  localparam int LEN_W       = 13;
  localparam int POWER_SHIFT = 16;
  localparam int MSQ_W       = 64;

  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_COEFFICIENT  = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_LENGTH = 1'b1;
  localparam logic [LEN_W-1:0]     LEN_RESET        = 13'd256;

  typedef enum logic [1:0] {
    OP_CMAG,
    OP_MAG1,
    OP_MAG2,
    OP_U
  } opsel_t;

  typedef struct packed {
    logic             accept;      // latch sample, load recursion operands
    logic             mac;         // issue one partial product
    opsel_t           a_sel;
    logic [IDX_W-1:0] a_dig;
    opsel_t           b_sel;
    logic [IDX_W-1:0] b_dig;
    logic             mac_sub;
    logic             mac_frac;    // extra shift by the coefficient fraction
    logic             update;      // recursion state update
    logic             pload;       // load power operands, clear delays
    logic             ustore;      // park |d1|*|c| for the cross term
    logic             root_start;
    logic             out_load;
  } cmd_t;

  typedef struct packed {
    logic block_end;
    logic neg;
    logic root_busy;
  } status_t;

endpackage

// File: design/gtd_isqrt.sv
module gtd_isqrt #(
  parameter int RAD_W = 82,
  localparam int ROOT_W = RAD_W / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              busy,
  output logic [ROOT_W-1:0] root
);

  localparam int ITER  = ROOT_W;
  localparam int REM_W = ROOT_W + 3;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [RAD_W-1:0]  rad_r;
  logic [REM_W-1:0]  rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             fits;

  // restoring square root, one result bit per cycle
  always_comb begin
    rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
    trial  = REM_W'({root_r, 2'b01});
    fits   = (rem_sh >= trial);
  end

  assign busy = |cnt_r;
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(ITER);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy) begin
      rad_r  <= rad_r << 2;
      rem_r  <= fits ? (rem_sh - trial) : rem_sh;
      root_r <= {root_r[ROOT_W-2:0], fits};
    end
  end

endmodule

// File: design/gtd_ctrl.sv
module gtd_ctrl #(
  parameter int A_DIGS = 2,
  parameter int U_DIGS = 3
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output gtd_pkg::cmd_t    cmd,
  input  gtd_pkg::status_t st
);

  import gtd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RMAC,
    S_RDRAIN,
    S_RUPD,
    S_PLOAD,
    S_UMAC,
    S_UDRAIN,
    S_USTORE,
    S_XMAC,
    S_SQ1,
    S_SQ2,
    S_PDRAIN,
    S_ROOT_GO,
    S_ROOT_WAIT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic             out_valid_r;

  logic             last_j;
  logic             last_i_u;
  logic             last_i_a;
  logic [IDX_W-1:0] j_adv;
  logic [IDX_W-1:0] i_adv;

  always_comb begin
    last_j   = (j_r == IDX_W'(A_DIGS - 1));
    last_i_u = (i_r == IDX_W'(U_DIGS - 1));
    last_i_a = (i_r == IDX_W'(A_DIGS - 1));
    j_adv    = last_j ? '0 : j_r + 1'b1;
    i_adv    = i_r + 1'b1;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          i_r <= '0;
          j_r <= '0;
          if (in_valid) state_r <= S_RMAC;
        end
        S_RMAC: begin
          j_r <= j_adv;
          if (last_j) state_r <= S_RDRAIN;
        end
        S_RDRAIN: state_r <= S_RUPD;
        S_RUPD: begin
          state_r <= st.block_end ? S_PLOAD : S_IDLE;
        end
        S_PLOAD: state_r <= S_UMAC;
        S_UMAC: begin
          j_r <= j_adv;
          if (last_j) state_r <= S_UDRAIN;
        end
        S_UDRAIN: state_r <= S_USTORE;
        S_USTORE: state_r <= S_XMAC;
        S_XMAC: begin
          j_r <= j_adv;
          if (last_j) i_r <= last_i_u ? '0 : i_adv;
          if (last_j && last_i_u) state_r <= S_SQ1;
        end
        S_SQ1: begin
          j_r <= j_adv;
          if (last_j) i_r <= last_i_a ? '0 : i_adv;
          if (last_j && last_i_a) state_r <= S_SQ2;
        end
        S_SQ2: begin
          j_r <= j_adv;
          if (last_j) i_r <= last_i_a ? '0 : i_adv;
          if (last_j && last_i_a) state_r <= S_PDRAIN;
        end
        S_PDRAIN: state_r <= S_ROOT_GO;
        S_ROOT_GO: state_r <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (!st.root_busy && (!out_valid_r || out_ready)) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.a_sel      = OP_CMAG;
    cmd.b_sel      = OP_MAG1;
    cmd.a_dig      = i_r;
    cmd.b_dig      = j_r;
    unique case (state_r)
      S_IDLE:   cmd.accept = in_valid;
      S_RMAC: begin
        cmd.mac     = 1'b1;
        cmd.mac_sub = st.neg;
      end
      S_RUPD:   cmd.update = 1'b1;
      S_PLOAD:  cmd.pload = 1'b1;
      S_UMAC:   cmd.mac = 1'b1;
      S_USTORE: cmd.ustore = 1'b1;
      S_XMAC: begin
        cmd.mac     = 1'b1;
        cmd.a_sel   = OP_U;
        cmd.b_sel   = OP_MAG2;
        cmd.mac_sub = !st.neg;
      end
      S_SQ1: begin
        cmd.mac      = 1'b1;
        cmd.a_sel    = OP_MAG1;
        cmd.b_sel    = OP_MAG1;
        cmd.mac_frac = 1'b1;
      end
      S_SQ2: begin
        cmd.mac      = 1'b1;
        cmd.a_sel    = OP_MAG2;
        cmd.b_sel    = OP_MAG2;
        cmd.mac_frac = 1'b1;
      end
      S_ROOT_GO: cmd.root_start = 1'b1;
      S_ROOT_WAIT: begin
        cmd.out_load = !st.root_busy && (!out_valid_r || out_ready);
      end
      default: ;
    endcase
  end

endmodule

// File: design/gtd_datapath.sv
module gtd_datapath #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int STATE_WIDTH     = 40,
  parameter int COEFF_FRAC_BITS = 14,
  parameter int MAX_BLOCK       = 4096,
  localparam int COEFF_W = COEFF_FRAC_BITS + 2,
  localparam int CFG_W   = (COEFF_W > gtd_pkg::LEN_W) ? COEFF_W : gtd_pkg::LEN_W
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gtd_pkg::REG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_W-1:0]               cfg_wdata,
  input  logic [SAMPLE_WIDTH-1:0]        sample,
  input  gtd_pkg::cmd_t                  cmd,
  output gtd_pkg::status_t               st,
  output logic [gtd_pkg::MSQ_W-1:0]      magnitude_squared,
  output logic [STATE_WIDTH-1:0]         magnitude
);

  import gtd_pkg::*;

  localparam int S     = STATE_WIDTH;
  localparam int F     = COEFF_FRAC_BITS;
  localparam int U_W   = S + COEFF_W;
  localparam int ACC_W = 2 * S + F + 3;
  localparam int P_W   = 2 * S + 1;
  localparam int RAD_W = 2 * S + 2;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int EXT_W = ((P_W > MSQ_W + POWER_SHIFT) ? P_W : MSQ_W + POWER_SHIFT) + 1;
  localparam int SUM_W = S + 3;

  // configuration
  logic signed [COEFF_W-1:0] coef_r;
  logic [LEN_W-1:0]          len_r;

  // recursion state
  logic signed [S-1:0]       d1_r;
  logic signed [S-1:0]       d2_r;
  logic [CNT_W-1:0]          cnt_r;
  logic signed [SAMPLE_WIDTH-1:0] s_r;

  // multiplier operands
  logic [S-1:0]              mag1_r;
  logic [S-1:0]              mag2_r;
  logic [COEFF_W-1:0]        cmag_r;
  logic [U_W-1:0]            u_r;
  logic                      neg_r;

  // MAC pipeline
  logic [2*DIG_W-1:0]        prod_r;
  logic                      pv_r;
  logic                      psub_r;
  logic [SH_W-1:0]           psh_r;
  logic [ACC_W-1:0]          acc_r;

  logic [MSQ_W-1:0]          msq_r;
  logic [S-1:0]              mag_r;

  function automatic logic [DIG_W-1:0] digit_of(input logic [OPW-1:0] v,
                                                input logic [IDX_W-1:0] idx);
    logic [DIG_W-1:0] d;
    unique case (idx)
      2'd0:    d = v[0 +: DIG_W];
      2'd1:    d = v[DIG_W +: DIG_W];
      2'd2:    d = v[2*DIG_W +: DIG_W];
      default: d = '0;
    endcase
    return d;
  endfunction

  logic [S-1:0]       d1_abs;
  logic [S-1:0]       d2_abs;
  logic [COEFF_W-1:0] c_abs;

  assign d1_abs = d1_r[S-1] ? (~d1_r + 1'b1) : d1_r;
  assign d2_abs = d2_r[S-1] ? (~d2_r + 1'b1) : d2_r;
  assign c_abs  = coef_r[COEFF_W-1] ? (~coef_r + 1'b1) : coef_r;

  // effective block length: zero means one, clamp at MAX_BLOCK
  logic [CMP_W-1:0] len_ext;
  logic [CMP_W-1:0] len_eff;
  logic [CNT_W-1:0] cnt_inc;

  always_comb begin
    len_ext = CMP_W'(len_r);
    priority if (len_r == '0) begin
      len_eff = CMP_W'(1);
    end else if (len_ext > CMP_W'(MAX_BLOCK)) begin
      len_eff = CMP_W'(MAX_BLOCK);
    end else begin
      len_eff = len_ext;
    end
    cnt_inc = cnt_r + 1'b1;
  end

  assign st.block_end = (CMP_W'(cnt_inc) >= len_eff);
  assign st.neg       = neg_r;

  // stage 1: digit select and multiply
  logic [OPW-1:0]   op_a;
  logic [OPW-1:0]   op_b;
  logic [DIG_W-1:0] dig_a;
  logic [DIG_W-1:0] dig_b;
  logic [IDX_W:0]   dsum;
  logic [SH_W-1:0]  sh;

  function automatic logic [OPW-1:0] pick(input opsel_t sel, input logic [COEFF_W-1:0] cm,
                                          input logic [S-1:0] m1, input logic [S-1:0] m2,
                                          input logic [U_W-1:0] u);
    logic [OPW-1:0] v;
    unique case (sel)
      OP_CMAG: v = OPW'(cm);
      OP_MAG1: v = OPW'(m1);
      OP_MAG2: v = OPW'(m2);
      OP_U:    v = OPW'(u);
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    op_a  = pick(cmd.a_sel, cmag_r, mag1_r, mag2_r, u_r);
    op_b  = pick(cmd.b_sel, cmag_r, mag1_r, mag2_r, u_r);
    dig_a = digit_of(op_a, cmd.a_dig);
    dig_b = digit_of(op_b, cmd.b_dig);
    dsum  = {1'b0, cmd.a_dig} + {1'b0, cmd.b_dig};
    sh    = SH_W'(dsum * DIG_W) + (cmd.mac_frac ? SH_W'(F) : '0);
  end

  // stage 2: shift and accumulate
  logic [ACC_W-1:0] addend;
  logic [ACC_W-1:0] acc_nxt;

  always_comb begin
    addend  = ACC_W'(prod_r) << psh_r;
    acc_nxt = psub_r ? (acc_r - addend) : (acc_r + addend);
  end

  // recursion: q0 = floor(c*d1 / 2^F) - d2 + sample, saturated
  logic signed [S+1:0]    pq;
  logic signed [SUM_W-1:0] sum;
  logic [3:0]             sum_top;
  logic signed [S-1:0]    q0_sat;

  always_comb begin
    pq      = acc_r[F +: S+2];
    sum     = SUM_W'(pq) - SUM_W'(d2_r) + SUM_W'(s_r);
    sum_top = sum[SUM_W-1:S-1];
    if ((&sum_top) || !(|sum_top)) begin
      q0_sat = sum[S-1:0];
    end else if (sum[SUM_W-1]) begin
      q0_sat = {1'b1, {(S-1){1'b0}}};
    end else begin
      q0_sat = {1'b0, {(S-1){1'b1}}};
    end
  end

  // power and output formatting
  logic [P_W-1:0]           p_val;
  logic [EXT_W-1:0]         p_ext;
  logic [EXT_W-POWER_SHIFT-1:0] p_shr;
  logic [MSQ_W-1:0]         msq_val;
  logic [S:0]               root;
  logic [S-1:0]             mag_val;

  always_comb begin
    p_val   = acc_r[F +: P_W];
    p_ext   = EXT_W'(p_val);
    p_shr   = p_ext[EXT_W-1:POWER_SHIFT];
    msq_val = (|p_shr[EXT_W-POWER_SHIFT-1:MSQ_W]) ? '1 : p_shr[MSQ_W-1:0];
    mag_val = root[S] ? '1 : root[S-1:0];
  end

  gtd_isqrt #(
    .RAD_W (RAD_W)
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (RAD_W'(p_val)),
    .busy     (st.root_busy),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      len_r  <= LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COEFFICIENT:  coef_r <= cfg_wdata[COEFF_W-1:0];
        REG_BLOCK_LENGTH: len_r  <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r  <= '0;
      d2_r  <= '0;
      cnt_r <= '0;
    end else if (cmd.update) begin
      d2_r  <= d1_r;
      d1_r  <= q0_sat;
      cnt_r <= st.block_end ? '0 : cnt_inc;
    end else if (cmd.pload) begin
      d1_r <= '0;
      d2_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= cmd.mac;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= dig_a * dig_b;
    psub_r <= cmd.mac_sub;
    psh_r  <= sh;

    if (cmd.accept || cmd.pload || cmd.ustore) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_nxt;
    end

    if (cmd.accept) begin
      s_r    <= sample;
      mag1_r <= d1_abs;
      cmag_r <= c_abs;
      neg_r  <= coef_r[COEFF_W-1] ^ d1_r[S-1];
    end else if (cmd.pload) begin
      mag1_r <= d1_abs;
      mag2_r <= d2_abs;
      cmag_r <= c_abs;
      neg_r  <= coef_r[COEFF_W-1] ^ d1_r[S-1] ^ d2_r[S-1];
    end

    if (cmd.ustore) u_r <= acc_r[U_W-1:0];

    if (cmd.out_load) begin
      msq_r <= msq_val;
      mag_r <= mag_val;
    end
  end

  assign magnitude_squared = msq_r;
  assign magnitude         = mag_r;

endmodule

// File: design/goertzel_tone_detector.sv
// Goertzel single-tone detector.
// in_*  : one signed sample per word. Each sample runs one step of the
//         recursion q0 = coeff*q1 - q2 + sample on a shared 24x24 multiplier.
// out_* : one word per block of block_length samples: the power shifted
//         right 16 (saturated to 64 bits) and the integer square root of the power.
// cfg_* : register 0 = coefficient (2cos(w), signed Q2.14),
//         register 1 = block_length (0 acts as 1, clamped to MAX_BLOCK).
//         Write only while the block is idle.
// Per sample: accept, two partial products, one accumulator drain, state
//   update; the next sample waits until the block is back in idle.
// Block end: the last sample of a block holds the input while the power
//   is formed from 16 partial products and then the square root unit
//   works out one root bit per cycle.
// Reset: delays and sample count clear, coefficient 0, block_length 256.
// Stall: the result waits in the output register while the next block
//   is taken in; a new result waits for the old one to leave.
module goertzel_tone_detector #(
  parameter int SAMPLE_WIDTH    = 16,
  parameter int STATE_WIDTH     = 40,
  parameter int COEFF_FRAC_BITS = 14,
  parameter int MAX_BLOCK       = 4096,
  localparam int COEFF_W = COEFF_FRAC_BITS + 2,
  localparam int CFG_W   = (COEFF_W > gtd_pkg::LEN_W) ? COEFF_W : gtd_pkg::LEN_W,
  localparam int IN_W    = ((SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_W   = ((gtd_pkg::MSQ_W + STATE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [gtd_pkg::REG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]              cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_W-1:0]               in_tdata,   // [SAMPLE_WIDTH-1:0] sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_W-1:0]              out_tdata   // magnitude_squared (low), magnitude
);

  import gtd_pkg::*;

  // digits per operand on the shared multiplier
  localparam int A_DIGS = (STATE_WIDTH + DIG_W - 1) / DIG_W;
  localparam int U_DIGS = (STATE_WIDTH + COEFF_W + DIG_W - 1) / DIG_W;

  cmd_t             cmd;
  status_t          st;
  logic [MSQ_W-1:0] msq;
  logic [STATE_WIDTH-1:0] mag;

  gtd_ctrl #(
    .A_DIGS (A_DIGS),
    .U_DIGS (U_DIGS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .cmd       (cmd),
    .st        (st)
  );

  gtd_datapath #(
    .SAMPLE_WIDTH    (SAMPLE_WIDTH),
    .STATE_WIDTH     (STATE_WIDTH),
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .MAX_BLOCK       (MAX_BLOCK)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata),
    .sample            (in_tdata[SAMPLE_WIDTH-1:0]),
    .cmd               (cmd),
    .st                (st),
    .magnitude_squared (msq),
    .magnitude         (mag)
  );

  // magnitude_squared in the low 64 bits, magnitude above it
  assign out_tdata = OUT_W'({mag, msq});

endmodule
